// ===== rtl/slxfr_pkg.sv =====
// Shared types, constants and codes for the sync/length/XOR frame receiver.
package slxfr_pkg;

    localparam int BYTE_W          = 8;
    localparam int IDX_W           = 5;
    localparam int SIZE_W          = 6;
    localparam int CFG_DATA_W      = 32;
    localparam int PADDR_W         = 3;
    localparam int MAX_PAYLOAD_DEF = 32;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h06;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h85;

    localparam logic [SIZE_W-1:0] PAYLOAD_SIZE_RST = 6'd1;

    // register index as decoded from paddr[2]
    localparam logic REG_PAYLOAD_SIZE = 1'b0;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SECOND,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CHECK,
        PH_READ,
        PH_LOAD
    } t_phase;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_store_ctl;

    typedef struct packed {
        logic readout;
        logic mem_wr;
        logic mem_rd;
    } t_ctrl_status;

endpackage

// ===== rtl/slxfr_if.sv =====
// Request channel interfaces: received link bytes in, verified payload bytes out.
interface slxfr_rx_if;
    logic                          valid;
    logic                          ready;
    logic [slxfr_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slxfr_out_if;
    logic                          valid;
    logic                          ready;
    logic [slxfr_pkg::BYTE_W-1:0]  payload_byte;
    logic [slxfr_pkg::IDX_W-1:0]   byte_index;
    logic                          last_byte;

    modport source (output valid, output payload_byte, output byte_index, output last_byte,
                    input ready);
    modport sink   (input valid, input payload_byte, input byte_index, input last_byte,
                    output ready);
endinterface

// ===== rtl/sync_length_xor_frame_receiver_unit.sv =====
// Top level of the sync/length/XOR frame receiver: config register, parser, frame store.
//
//  channel   | dir | handshake            | payload
//  ----------+-----+----------------------+-------------------------------------------
//  i_rx      | in  | valid / ready        | rx_byte[7:0]
//  o_res     | out | valid / ready        | payload_byte[7:0], byte_index[4:0], last_byte
//  APB       | in  | psel/penable/pwrite  | paddr[2:0], pwdata[31:0], prdata[31:0]
//
// Flow: link bytes are taken whenever valid while the receiver hunts, checks the header,
// the length, the payload and the checksum. After a good checksum the input stalls while
// the payload is read back from the frame store byte by byte: a store read, then an
// output register load, since the store has a single read port with registered read data.
// Reset: synchronous, active low; clears the parser and sets payload_size to 1. The frame
// store is not cleared. A stalled output holds its request and the readout waits for it;
// the next link byte is taken as soon as the last payload byte sits in the output register.
module sync_length_xor_frame_receiver_unit #(
    parameter int MAX_PAYLOAD = slxfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    slxfr_rx_if.sink                         i_rx,
    slxfr_out_if.source                      o_res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [slxfr_pkg::PADDR_W-1:0]    paddr,
    input  logic [slxfr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [slxfr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready
);

    // store address and frame counter widths
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CW = $clog2(MAX_PAYLOAD + 1);

    logic [slxfr_pkg::SIZE_W-1:0] r_payload_size;
    logic                         w_cfg_hit;
    logic                         w_cfg_wr;

    slxfr_pkg::t_store_ctl        w_store_ctl;
    slxfr_pkg::t_ctrl_status      w_status;
    logic [AW-1:0]                w_waddr;
    logic [AW-1:0]                w_raddr;
    logic [slxfr_pkg::BYTE_W-1:0] w_wdata;
    logic [slxfr_pkg::BYTE_W-1:0] w_rdata;

    // APB: the access phase writes; a write to any other slot is ignored
    assign pready    = 1'b1;
    assign w_cfg_hit = (paddr[2] == slxfr_pkg::REG_PAYLOAD_SIZE);
    assign w_cfg_wr  = psel && penable && pwrite && pready && w_cfg_hit;
    assign prdata    = w_cfg_hit ? slxfr_pkg::CFG_DATA_W'(r_payload_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_size <= slxfr_pkg::PAYLOAD_SIZE_RST;
        end else if (w_cfg_wr) begin
            r_payload_size <= pwdata[slxfr_pkg::SIZE_W-1:0];
        end
    end

    // parser, checksum and readout sequencing
    slxfr_ctrl #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr       (w_cfg_wr),
        .i_payload_size (r_payload_size),
        .i_rx           (i_rx),
        .o_res          (o_res),
        .o_store_ctl    (w_store_ctl),
        .o_waddr        (w_waddr),
        .o_wdata        (w_wdata),
        .o_raddr        (w_raddr),
        .i_rdata        (w_rdata),
        .o_status       (w_status)
    );

    // payload buffer; writes and reads fall in separate phases, so no forwarding is needed
    slxfr_store #(
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (w_store_ctl),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // the store never sees a write and a read in the same cycle
    a_store_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_status.mem_wr && w_status.mem_rd))
        else $error("frame store written and read in one cycle");

    // no link byte is taken while the payload is being read out
    a_no_rx_in_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.readout |-> !i_rx.ready)
        else $error("input ready during readout");

    // readout only starts straight after an accepted checksum byte
    a_readout_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_status.readout) |-> $past(i_rx.valid && i_rx.ready))
        else $error("readout started without a checksum byte");

    // the marked byte sits at the configured end of the payload
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.last_byte) |->
            (32'(o_res.byte_index) == ((32'(r_payload_size) - 32'd1) & 32'd31)))
        else $error("last byte at wrong index");

endmodule

// ===== rtl/slxfr_store.sv =====
// Frame store: one write port, one read port, registered read data.
module slxfr_store #(
    parameter int DEPTH = slxfr_pkg::MAX_PAYLOAD_DEF,
    parameter int AW    = 5
) (
    input  logic                         i_clk,
    input  slxfr_pkg::t_store_ctl        i_ctl,
    input  logic [AW-1:0]                i_waddr,
    input  logic [slxfr_pkg::BYTE_W-1:0] i_wdata,
    input  logic [AW-1:0]                i_raddr,
    output logic [slxfr_pkg::BYTE_W-1:0] o_rdata
);

    logic [slxfr_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [slxfr_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/slxfr_ctrl.sv =====
// Frame parser and readout sequencer around the frame store.
module slxfr_ctrl #(
    parameter int MAX_PAYLOAD = slxfr_pkg::MAX_PAYLOAD_DEF,
    parameter int AW          = 5,
    parameter int CW          = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr,
    input  logic [slxfr_pkg::SIZE_W-1:0] i_payload_size,
    slxfr_rx_if.sink                     i_rx,
    slxfr_out_if.source                  o_res,
    output slxfr_pkg::t_store_ctl        o_store_ctl,
    output logic [AW-1:0]                o_waddr,
    output logic [slxfr_pkg::BYTE_W-1:0] o_wdata,
    output logic [AW-1:0]                o_raddr,
    input  logic [slxfr_pkg::BYTE_W-1:0] i_rdata,
    output slxfr_pkg::t_ctrl_status      o_status
);

    slxfr_pkg::t_phase            r_phase, n_phase;
    logic [CW-1:0]                r_count, n_count;
    logic [slxfr_pkg::BYTE_W-1:0] r_xor, n_xor;
    logic [CW-1:0]                r_rd_idx, n_rd_idx;

    logic                          r_out_valid, n_out_valid;
    logic [slxfr_pkg::BYTE_W-1:0]  r_out_byte, n_out_byte;
    logic [slxfr_pkg::IDX_W-1:0]   r_out_idx, n_out_idx;
    logic                          r_out_last, n_out_last;

    logic                          w_in_ready;
    logic                          w_in_acc;
    logic [slxfr_pkg::BYTE_W-1:0]  w_rx;
    logic [CW-1:0]                 w_count_inc;
    logic                          w_payload_end;
    logic                          w_size_ok;
    logic                          w_rd_last;
    logic                          w_out_free;
    logic [31:0]                   w_rd_idx_ext;
    slxfr_pkg::t_store_ctl         w_store;

    assign w_in_ready = (r_phase == slxfr_pkg::PH_HUNT)    ||
                        (r_phase == slxfr_pkg::PH_SECOND)  ||
                        (r_phase == slxfr_pkg::PH_LENGTH)  ||
                        (r_phase == slxfr_pkg::PH_PAYLOAD) ||
                        (r_phase == slxfr_pkg::PH_CHECK);
    assign w_in_acc   = i_rx.valid && w_in_ready;
    assign w_rx       = i_rx.rx_byte;

    assign w_count_inc   = r_count + CW'(1);
    assign w_payload_end = (32'(w_count_inc) >= 32'(i_payload_size)) ||
                           (32'(w_count_inc) >= MAX_PAYLOAD);
    assign w_size_ok     = (i_payload_size != '0) && (32'(i_payload_size) <= MAX_PAYLOAD);
    assign w_rd_last     = (r_rd_idx + CW'(1)) == r_count;
    assign w_out_free    = !r_out_valid || o_res.ready;
    assign w_rd_idx_ext  = 32'(r_rd_idx);

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_xor       = r_xor;
        n_rd_idx    = r_rd_idx;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_byte  = r_out_byte;
        n_out_idx   = r_out_idx;
        n_out_last  = r_out_last;
        w_store     = '0;
        case (r_phase)
            slxfr_pkg::PH_HUNT: begin
                if (w_in_acc && (w_rx == slxfr_pkg::SYNC_FIRST)) begin
                    n_phase = slxfr_pkg::PH_SECOND;
                end
            end
            slxfr_pkg::PH_SECOND: begin
                if (w_in_acc) begin
                    n_phase = (w_rx == slxfr_pkg::SYNC_SECOND) ? slxfr_pkg::PH_LENGTH
                                                               : slxfr_pkg::PH_HUNT;
                end
            end
            slxfr_pkg::PH_LENGTH: begin
                if (w_in_acc) begin
                    if (w_size_ok && (w_rx == {2'b00, i_payload_size})) begin
                        n_xor   = w_rx;
                        n_count = '0;
                        n_phase = slxfr_pkg::PH_PAYLOAD;
                    end else begin
                        n_phase = slxfr_pkg::PH_HUNT;
                        n_count = '0;
                        n_xor   = '0;
                    end
                end
            end
            slxfr_pkg::PH_PAYLOAD: begin
                if (w_in_acc) begin
                    w_store.wr_en = 1'b1;
                    n_xor         = r_xor ^ w_rx;
                    n_count       = w_count_inc;
                    if (w_payload_end) begin
                        n_phase = slxfr_pkg::PH_CHECK;
                    end
                end
            end
            slxfr_pkg::PH_CHECK: begin
                if (w_in_acc) begin
                    if (w_rx == r_xor) begin
                        n_rd_idx = '0;
                        n_phase  = slxfr_pkg::PH_READ;
                    end else begin
                        n_phase = slxfr_pkg::PH_HUNT;
                        n_count = '0;
                        n_xor   = '0;
                    end
                end
            end
            slxfr_pkg::PH_READ: begin
                w_store.rd_en = 1'b1;
                n_phase       = slxfr_pkg::PH_LOAD;
            end
            slxfr_pkg::PH_LOAD: begin
                // read data holds in the store until the output register frees up
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = i_rdata;
                    n_out_idx   = w_rd_idx_ext[slxfr_pkg::IDX_W-1:0];
                    n_out_last  = w_rd_last;
                    if (w_rd_last) begin
                        n_phase = slxfr_pkg::PH_HUNT;
                        n_count = '0;
                        n_xor   = '0;
                    end else begin
                        n_rd_idx = r_rd_idx + CW'(1);
                        n_phase  = slxfr_pkg::PH_READ;
                    end
                end
            end
            default: begin
                n_phase = slxfr_pkg::PH_HUNT;
                n_count = '0;
                n_xor   = '0;
            end
        endcase
        // drop any frame in progress on a size write
        if (i_cfg_wr) begin
            n_phase = slxfr_pkg::PH_HUNT;
            n_count = '0;
            n_xor   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= slxfr_pkg::PH_HUNT;
            r_count     <= '0;
            r_xor       <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_xor       <= n_xor;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

    assign i_rx.ready         = w_in_ready;
    assign o_res.valid        = r_out_valid;
    assign o_res.payload_byte = r_out_byte;
    assign o_res.byte_index   = r_out_idx;
    assign o_res.last_byte    = r_out_last;

    assign o_store_ctl = w_store;
    assign o_waddr     = r_count[AW-1:0];
    assign o_wdata     = w_rx;
    assign o_raddr     = r_rd_idx[AW-1:0];

    assign o_status.readout = (r_phase == slxfr_pkg::PH_READ) ||
                              (r_phase == slxfr_pkg::PH_LOAD);
    assign o_status.mem_wr  = w_store.wr_en;
    assign o_status.mem_rd  = w_store.rd_en;

endmodule

// ===== test/tb_top.sv =====
// Testbench for the sync/length/XOR frame receiver: link byte stimulus and payload checks.
`timescale 1ns / 100ps
module tb_top;

    localparam int BYTE_W        = slxfr_pkg::BYTE_W;
    localparam int IDX_W         = slxfr_pkg::IDX_W;
    localparam int SIZE_W        = slxfr_pkg::SIZE_W;
    localparam int PADDR_W       = slxfr_pkg::PADDR_W;
    localparam int CFG_DATA_W    = slxfr_pkg::CFG_DATA_W;
    localparam int MAX_PAYLOAD   = slxfr_pkg::MAX_PAYLOAD_DEF;
    localparam int IDLE_PCT      = 23;    // chance in a hundred that a side idles
    localparam int STALL_LIMIT   = 1000;  // cycles with no request moving before giving up
    localparam int SETTLE_CYCLES = 12;    // covers the readout tail after the last payload byte

    // APB byte addresses: payload_size at index 0, index 1 is not mapped
    localparam logic [PADDR_W-1:0] PAYLOAD_SIZE_ADDR = 3'd0;
    localparam logic [PADDR_W-1:0] SPARE_ADDR        = 3'd4;

    typedef enum int {
        FLAW_NONE,
        FLAW_SECOND,
        FLAW_LENGTH,
        FLAW_CHECKSUM
    } t_frame_flaw;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [IDX_W-1:0]  byte_index;
        logic              last_byte;
    } t_payload_beat;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [PADDR_W-1:0]    paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    slxfr_rx_if  rx ();
    slxfr_out_if res ();

    sync_length_xor_frame_receiver_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow of the receiver: parser phase, payload count, running XOR, frame copy and the
    // payload_size setting, advanced once per accepted link byte.
    slxfr_pkg::t_phase  rx_phase;
    int                 stored;
    logic [BYTE_W-1:0]  running_xor;
    logic [BYTE_W-1:0]  frame_copy [MAX_PAYLOAD];
    logic [SIZE_W-1:0]  size_setting;

    t_payload_beat      payload_due [$];   // verified payload bytes still to come out
    logic [BYTE_W-1:0]  link_bytes [$];    // link bytes waiting for the driver
    t_payload_beat      head;
    int                 mismatches  = 0;
    int                 quiet_cycles = 0;
    int                 phase_bytes  = 0;
    bit                 steady       = 1'b0; // suppress idling on both sides

    function automatic void restart_hunt();
        rx_phase    = slxfr_pkg::PH_HUNT;
        stored      = 0;
        running_xor = '0;
    endfunction

    // Advance the shadow by one link byte; queue the payload of a frame that verifies.
    function automatic void track_link_byte(input logic [BYTE_W-1:0] b);
        t_payload_beat beat;
        int            i;
        case (rx_phase)
            slxfr_pkg::PH_SECOND: begin
                // a bad second header byte is consumed, never re-taken as a sync byte
                rx_phase = (b == slxfr_pkg::SYNC_SECOND) ? slxfr_pkg::PH_LENGTH
                                                         : slxfr_pkg::PH_HUNT;
            end
            slxfr_pkg::PH_LENGTH: begin
                // a setting of zero or above the store depth never matches
                if (size_setting >= 1 && int'(size_setting) <= MAX_PAYLOAD &&
                    int'(b) == int'(size_setting)) begin
                    running_xor = b;
                    stored      = 0;
                    rx_phase    = slxfr_pkg::PH_PAYLOAD;
                end else begin
                    restart_hunt();
                end
            end
            slxfr_pkg::PH_PAYLOAD: begin
                if (stored < MAX_PAYLOAD) frame_copy[stored] = b;
                running_xor = running_xor ^ b;
                stored++;
                if (stored >= int'(size_setting) || stored >= MAX_PAYLOAD)
                    rx_phase = slxfr_pkg::PH_CHECK;
            end
            slxfr_pkg::PH_CHECK: begin
                if (b == running_xor) begin
                    for (i = 0; i < stored && i < MAX_PAYLOAD; i++) begin
                        beat.payload_byte = frame_copy[i];
                        beat.byte_index   = i[IDX_W-1:0];
                        beat.last_byte    = (i + 1 == stored) || (i + 1 == MAX_PAYLOAD);
                        payload_due.push_back(beat);
                    end
                end
                // a bad checksum drops the frame without a word
                restart_hunt();
            end
            default: begin
                // hunting, and any phase code the parser never uses
                if (b == slxfr_pkg::SYNC_FIRST) rx_phase = slxfr_pkg::PH_SECOND;
                else restart_hunt();
            end
        endcase
    endfunction

    // Link driver: hold a request until it is taken, then offer the next or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx.valid <= 1'b0;
        end else if (!rx.valid || rx.ready) begin
            if (link_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                rx.valid   <= 1'b1;
                rx.rx_byte <= link_bytes.pop_front();
            end else begin
                rx.valid <= 1'b0;
            end
        end
    end

    // Payload sink: stall at random, except through the steady stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            res.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Monitor: check each payload request against the oldest expectation, feed the
    // shadow with each accepted link byte, and watch for a hung handshake.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res.valid && res.ready) begin
                if (payload_due.size() == 0) begin
                    $error("payload request with nothing due: payload_byte %0h index %0d",
                           res.payload_byte, res.byte_index);
                    mismatches++;
                end else begin
                    head = payload_due.pop_front();
                    if (res.payload_byte !== head.payload_byte) begin
                        $error("payload_byte: expected %0h, got %0h",
                               head.payload_byte, res.payload_byte);
                        mismatches++;
                    end
                    if (res.byte_index !== head.byte_index) begin
                        $error("byte_index: expected %0d, got %0d",
                               head.byte_index, res.byte_index);
                        mismatches++;
                    end
                    if (res.last_byte !== head.last_byte) begin
                        $error("last_byte: expected %0b, got %0b",
                               head.last_byte, res.last_byte);
                        mismatches++;
                    end
                end
            end
            if (rx.valid && rx.ready) track_link_byte(rx.rx_byte);

            if ((res.valid && res.ready) || (rx.valid && rx.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send(input logic [BYTE_W-1:0] b);
        link_bytes.push_back(b);
        phase_bytes++;
    endtask

    // Queue one frame of n payload bytes with random content, spoilt as the flaw says.
    task automatic queue_frame(input int n, input t_frame_flaw flaw);
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] sum;
        int                k;
        send(slxfr_pkg::SYNC_FIRST);
        if (flaw == FLAW_SECOND) begin
            b = BYTE_W'($urandom_range(0, 255));
            if (b == slxfr_pkg::SYNC_SECOND) b = b ^ 8'h01;
            send(b);
            return;
        end
        send(slxfr_pkg::SYNC_SECOND);
        b = n[BYTE_W-1:0];
        if (flaw == FLAW_LENGTH) begin
            b = BYTE_W'($urandom_range(0, 255));
            if (int'(b) == n) b = b ^ 8'h20;
        end
        send(b);
        sum = n[BYTE_W-1:0];
        for (k = 0; k < n; k++) begin
            b = BYTE_W'($urandom_range(0, 255));
            sum = sum ^ b;
            send(b);
        end
        if (flaw == FLAW_CHECKSUM) sum = sum ^ (8'h01 << $urandom_range(0, 7));
        send(sum);
    endtask

    // Wait until every queued byte is taken and every payload byte is out, then let the
    // readout tail settle before touching the register.
    task automatic wait_idle();
        while (link_bytes.size() != 0 || rx.valid || payload_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes it at the edge after.
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // a write to payload_size also drops any frame in progress; spare index is ignored
        if (addr[2] == slxfr_pkg::REG_PAYLOAD_SIZE) begin
            size_setting = data[SIZE_W-1:0];
            restart_hunt();
        end
        @(negedge i_clk);
    endtask

    // Run one phase of random traffic: mostly well-formed frames, some spoilt, some noise.
    task automatic random_round(input int byte_budget);
        int pick;
        phase_bytes = 0;
        while (phase_bytes < byte_budget) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)       queue_frame(int'(size_setting), FLAW_NONE);
            else if (pick == 6) queue_frame(int'(size_setting), FLAW_SECOND);
            else if (pick == 7) queue_frame(int'(size_setting), FLAW_LENGTH);
            else if (pick == 8) queue_frame(int'(size_setting), FLAW_CHECKSUM);
            else                send(BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        rx.valid     = 1'b0;
        rx.rx_byte   = '0;
        res.ready    = 1'b0;
        size_setting = slxfr_pkg::PAYLOAD_SIZE_RST;
        restart_hunt();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset size of one byte.
        // good frames carrying the lowest and highest payload byte
        send(slxfr_pkg::SYNC_FIRST); send(slxfr_pkg::SYNC_SECOND);
        send(8'h01); send(8'h00); send(8'h01);
        send(slxfr_pkg::SYNC_FIRST); send(slxfr_pkg::SYNC_SECOND);
        send(8'h01); send(8'hFF); send(8'hFE);
        // bad second header byte: the repeated sync byte is consumed, the 0x85 falls in hunt
        send(slxfr_pkg::SYNC_FIRST); send(slxfr_pkg::SYNC_FIRST); send(slxfr_pkg::SYNC_SECOND);
        // length that does not match the setting
        send(slxfr_pkg::SYNC_FIRST); send(slxfr_pkg::SYNC_SECOND); send(8'h02);
        // bad checksum
        send(slxfr_pkg::SYNC_FIRST); send(slxfr_pkg::SYNC_SECOND);
        send(8'h01); send(8'h55); send(8'h00);
        // noise while hunting
        send(8'h00); send(8'hFF);
        wait_idle();

        // Largest size, upper data bits set to show they are masked off; the spare
        // index must leave the setting alone.
        apb_write(PAYLOAD_SIZE_ADDR, 32'hFFFF_FFE0);
        apb_write(SPARE_ADDR, 32'h0000_0007);
        steady = 1'b1;
        queue_frame(MAX_PAYLOAD, FLAW_NONE);
        wait_idle();
        steady = 1'b0;
        // start a frame, then abandon it with a register write
        send(slxfr_pkg::SYNC_FIRST); send(slxfr_pkg::SYNC_SECOND); send(8'h20);
        send(BYTE_W'($urandom_range(0, 255))); send(BYTE_W'($urandom_range(0, 255)));
        send(BYTE_W'($urandom_range(0, 255)));
        wait_idle();

        // Unusable sizes: every frame dies at the length byte.
        apb_write(PAYLOAD_SIZE_ADDR, 32'h0000_0000);
        queue_frame(0, FLAW_NONE);
        send(slxfr_pkg::SYNC_FIRST); send(slxfr_pkg::SYNC_SECOND); send(8'h40); send(8'h00);
        wait_idle();
        apb_write(PAYLOAD_SIZE_ADDR, 32'h0000_003F);
        send(slxfr_pkg::SYNC_FIRST); send(slxfr_pkg::SYNC_SECOND); send(8'h3F);
        send(BYTE_W'($urandom_range(0, 255))); send(BYTE_W'($urandom_range(0, 255)));
        send(BYTE_W'($urandom_range(0, 255)));
        wait_idle();

        // Random part: smallest size, then one small random size.
        apb_write(PAYLOAD_SIZE_ADDR, 32'h0000_0001);
        random_round(8);
        wait_idle();
        apb_write(PAYLOAD_SIZE_ADDR, $urandom_range(2, 8));
        random_round(8);
        // hold the link until the payload catches up, then carry on at the same size
        wait_idle();
        random_round(6);
        wait_idle();

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/slxfr_pkg.sv
rtl/slxfr_if.sv
rtl/slxfr_store.sv
rtl/slxfr_ctrl.sv
rtl/sync_length_xor_frame_receiver_unit.sv
test/tb_top.sv
